@@ src/tlca_pkg.sv @@
`timescale 1ns / 1ps

package tlca_pkg;

    localparam int FIELD_W = 10;
    localparam int OP_W    = 2;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_Q_DU,
        ST_Q_DV,
        ST_L1_READ,
        ST_L1_JUMP,
        ST_L1_DEPTH,
        ST_L1_CHECK,
        ST_L2_READ,
        ST_L2_A,
        ST_L2_B,
        ST_FIN_READ,
        ST_FIN,
        ST_B_ZERO,
        ST_B_READ,
        ST_B_PARENT,
        ST_B_WRITE,
        ST_DONE
    } state_t;

endpackage

@@ src/tree_lowest_common_ancestor.sv @@
`timescale 1ns / 1ps

// lowest common ancestor engine (binary lifting) for a rooted tree
// input words on s_*: tuser selects load, build or query; tdata carries the
// node, its parent and depth (load) or the two query nodes
// every input word gives exactly one result word on m_*: the ancestor in
// tdata and an answer flag in tuser (set only for a query)
// cfg_wr_en/cfg_wr_data set node_count; write it only while the block is idle
// one word is handled at a time; s_tready is high only while idle
// a query runs as a chain of dependent reads of the jump and depth
// memories, each with a single read port; build visits every node
// from 1 to node_count at each level above zero, one memory
// read per step of the sequencer
// reset clears control and sets node_count to 1; the tables hold nothing
// valid until loaded and built
// a stalled receiver holds the result in the output register and the
// block waits for it before it puts out the next result
module tree_lowest_common_ancestor
    import tlca_pkg::*;
#(
    parameter int MAX_NODES  = 1024,
    parameter int LOG_LEVELS = 10
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // node, parent_node, node_depth, other_node
    input  logic [1:0]  s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // ancestor, zero fill
    output logic        m_tuser,   // answer_valid
    input  logic        cfg_wr_en,
    input  logic [9:0]  cfg_wr_data
);

    localparam int NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int LW = (LOG_LEVELS > 1) ? $clog2(LOG_LEVELS) : 1;
    localparam int AW = NW + LW;
    localparam int EW = 17;
    localparam logic [EW-1:0] MAX_E  = EW'(MAX_NODES);
    localparam logic [EW-1:0] LAST_E = EW'(MAX_NODES - 1);
    localparam logic [LW-1:0] TOP_LV = LW'(LOG_LEVELS - 1);

    typedef struct packed {
        logic          none;
        logic [NW-1:0] node;
    } entry_t;

    function automatic logic [NW-1:0] to_node(input logic [FIELD_W-1:0] x);
        logic [25:0] t;
        t = {16'b0, x};
        return t[NW-1:0];
    endfunction

    function automatic logic [FIELD_W-1:0] to_field(input logic [NW-1:0] x);
        logic [25:0] t;
        t = 26'(x);
        return t[FIELD_W-1:0];
    endfunction

    function automatic logic [LW-1:0] capped_log2(input logic [FIELD_W-1:0] x);
        logic [LW-1:0] lg;
        lg = '0;
        for (int k = 1; k < FIELD_W; k++)
        begin
            if (x[k])
            begin
                if (k > LOG_LEVELS - 1)
                    lg = TOP_LV;
                else
                    lg = LW'(k);
            end
        end
        return lg;
    endfunction

    // memories
    entry_t             jt_mem [2**AW];
    logic [FIELD_W-1:0] dt_mem [MAX_NODES];

    logic               jt_we;
    logic [AW-1:0]      jt_waddr;
    entry_t             jt_wdata;
    logic [AW-1:0]      jt_raddr;
    entry_t             jt_rdata;
    logic               dt_we;
    logic [NW-1:0]      dt_waddr;
    logic [FIELD_W-1:0] dt_wdata;
    logic [NW-1:0]      dt_raddr;
    logic [FIELD_W-1:0] dt_rdata;

    always_ff @(posedge clk)
    begin
        if (jt_we)
            jt_mem[jt_waddr] <= jt_wdata;
        jt_rdata <= jt_mem[jt_raddr];
        if (dt_we)
            dt_mem[dt_waddr] <= dt_wdata;
        dt_rdata <= dt_mem[dt_raddr];
    end

    state_t             state_reg, state_next;
    logic [FIELD_W-1:0] nc_reg;
    logic [NW-1:0]      u_reg, u_next, v_reg, v_next, i_reg, i_next;
    entry_t             a_reg, a_next;
    logic [FIELD_W-1:0] du_reg, du_next, dv_reg, dv_next;
    logic [LW-1:0]      lv_reg, lv_next, lg_reg, lg_next;
    logic [FIELD_W-1:0] ans_reg, ans_next;
    logic               flag_reg, flag_next;
    logic               ov_reg, ov_next;
    logic [FIELD_W-1:0] oa_reg, oa_next;
    logic               of_reg, of_next;

    logic [FIELD_W-1:0] f_node, f_parent, f_depth, f_other;
    logic               accept, i_last;

    assign f_node   = s_tdata[9:0];
    assign f_parent = s_tdata[19:10];
    assign f_depth  = s_tdata[29:20];
    assign f_other  = s_tdata[39:30];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = ov_reg;
    assign m_tdata  = {6'b0, oa_reg};
    assign m_tuser  = of_reg;

    assign i_last = (EW'(i_reg) >= EW'(nc_reg)) || (EW'(i_reg) == LAST_E);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            nc_reg    <= 10'd1;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            if (cfg_wr_en)
                nc_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg    <= u_next;
        v_reg    <= v_next;
        i_reg    <= i_next;
        a_reg    <= a_next;
        du_reg   <= du_next;
        dv_reg   <= dv_next;
        lv_reg   <= lv_next;
        lg_reg   <= lg_next;
        ans_reg  <= ans_next;
        flag_reg <= flag_next;
        oa_reg   <= oa_next;
        of_reg   <= of_next;
    end

    always_comb
    begin
        state_next = state_reg;
        u_next     = u_reg;
        v_next     = v_reg;
        i_next     = i_reg;
        a_next     = a_reg;
        du_next    = du_reg;
        dv_next    = dv_reg;
        lv_next    = lv_reg;
        lg_next    = lg_reg;
        ans_next   = ans_reg;
        flag_next  = flag_reg;
        oa_next    = oa_reg;
        of_next    = of_reg;
        ov_next    = ov_reg && !m_tready;
        jt_we      = 1'b0;
        jt_waddr   = {u_reg, lv_reg};
        jt_wdata   = '{none: 1'b1, node: '0};
        jt_raddr   = {u_reg, lv_reg};
        dt_we      = 1'b0;
        dt_waddr   = to_node(f_node);
        dt_wdata   = f_depth;
        dt_raddr   = u_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    u_next     = to_node(f_node);
                    v_next     = to_node(f_other);
                    ans_next   = '0;
                    flag_next  = 1'b0;
                    state_next = ST_DONE;
                    unique case (s_tuser)
                        OP_LOAD:
                        begin
                            if (f_node != '0 && EW'(f_node) < MAX_E)
                            begin
                                jt_we    = 1'b1;
                                jt_waddr = {to_node(f_node), LW'(0)};
                                jt_wdata = (EW'(f_parent) < MAX_E) ?
                                           '{none: 1'b0, node: to_node(f_parent)} :
                                           '{none: 1'b1, node: '0};
                                dt_we    = 1'b1;
                            end
                        end
                        OP_BUILD:
                        begin
                            lv_next    = '0;
                            lg_next    = capped_log2(nc_reg);
                            state_next = ST_B_ZERO;
                        end
                        OP_QUERY:
                        begin
                            flag_next = 1'b1;
                            if (EW'(f_node) < MAX_E && EW'(f_other) < MAX_E)
                            begin
                                dt_raddr   = to_node(f_node);
                                state_next = ST_Q_DU;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_Q_DU:
            begin
                du_next    = dt_rdata;
                dt_raddr   = v_reg;
                state_next = ST_Q_DV;
            end
            ST_Q_DV:
            begin
                // deeper node goes to u
                if (du_reg < dt_rdata)
                begin
                    u_next  = v_reg;
                    v_next  = u_reg;
                    dv_next = du_reg;
                    lg_next = capped_log2(dt_rdata);
                    lv_next = capped_log2(dt_rdata);
                end
                else
                begin
                    dv_next = dt_rdata;
                    lg_next = capped_log2(du_reg);
                    lv_next = capped_log2(du_reg);
                end
                state_next = ST_L1_READ;
            end
            ST_L1_READ:
            begin
                jt_raddr   = {u_reg, lv_reg};
                state_next = ST_L1_JUMP;
            end
            ST_L1_JUMP:
            begin
                a_next = jt_rdata;
                if (jt_rdata.none)
                begin
                    if (lv_reg == '0)
                        state_next = ST_L1_CHECK;
                    else
                    begin
                        lv_next    = lv_reg - 1'b1;
                        state_next = ST_L1_READ;
                    end
                end
                else
                begin
                    dt_raddr   = jt_rdata.node;
                    state_next = ST_L1_DEPTH;
                end
            end
            ST_L1_DEPTH:
            begin
                if (dt_rdata >= dv_reg)
                    u_next = a_reg.node;
                if (lv_reg == '0)
                    state_next = ST_L1_CHECK;
                else
                begin
                    lv_next    = lv_reg - 1'b1;
                    state_next = ST_L1_READ;
                end
            end
            ST_L1_CHECK:
            begin
                if (u_reg == v_reg)
                begin
                    ans_next   = to_field(u_reg);
                    state_next = ST_DONE;
                end
                else
                begin
                    lv_next    = lg_reg;
                    state_next = ST_L2_READ;
                end
            end
            ST_L2_READ:
            begin
                jt_raddr   = {u_reg, lv_reg};
                state_next = ST_L2_A;
            end
            ST_L2_A:
            begin
                a_next     = jt_rdata;
                jt_raddr   = {v_reg, lv_reg};
                state_next = ST_L2_B;
            end
            ST_L2_B:
            begin
                if (lv_reg == '0)
                    state_next = ST_FIN_READ;
                else
                begin
                    lv_next    = lv_reg - 1'b1;
                    state_next = ST_L2_READ;
                end
                if (!a_reg.none && jt_rdata != a_reg)
                begin
                    u_next = a_reg.node;
                    v_next = jt_rdata.node;
                    if (jt_rdata.none)
                    begin
                        ans_next   = '0;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_FIN_READ:
            begin
                jt_raddr   = {u_reg, LW'(0)};
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                ans_next   = jt_rdata.none ? '0 : to_field(jt_rdata.node);
                state_next = ST_DONE;
            end
            ST_B_ZERO:
            begin
                // root slot of node zero reads as none at every level in use
                jt_we    = 1'b1;
                jt_waddr = {NW'(0), lv_reg};
                jt_wdata = '{none: 1'b1, node: '0};
                if (lv_reg == lg_reg)
                begin
                    if (lg_reg == '0)
                        state_next = ST_DONE;
                    else
                    begin
                        lv_next    = LW'(1);
                        i_next     = NW'(1);
                        state_next = ST_B_READ;
                    end
                end
                else
                    lv_next = lv_reg + 1'b1;
            end
            ST_B_READ:
            begin
                jt_raddr   = {i_reg, lv_reg - 1'b1};
                state_next = ST_B_PARENT;
            end
            ST_B_PARENT, ST_B_WRITE:
            begin
                jt_waddr = {i_reg, lv_reg};
                jt_wdata = jt_rdata;
                if (state_reg == ST_B_PARENT && !jt_rdata.none)
                begin
                    jt_raddr   = {jt_rdata.node, lv_reg - 1'b1};
                    state_next = ST_B_WRITE;
                end
                else
                begin
                    jt_we = 1'b1;
                    if (state_reg == ST_B_PARENT)
                        jt_wdata = '{none: 1'b1, node: '0};
                    if (i_last)
                    begin
                        if (lv_reg == lg_reg)
                            state_next = ST_DONE;
                        else
                        begin
                            lv_next    = lv_reg + 1'b1;
                            i_next     = NW'(1);
                            state_next = ST_B_READ;
                        end
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_B_READ;
                    end
                end
            end
            ST_DONE:
            begin
                if (!ov_reg || m_tready)
                begin
                    ov_next    = 1'b1;
                    oa_next    = ans_reg;
                    of_next    = flag_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import tlca_pkg::*;

    localparam int NODES  = 1024;
    localparam int LEVELS = 10;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [1:0] op;
        logic [9:0] node;
        logic [9:0] parent;
        logic [9:0] depth;
        logic [9:0] other;
        bit         fixed;
        logic [9:0] fixed_anc;
        bit         fixed_ans;
    } word_t;

    typedef struct {
        logic [9:0] anc;
        bit         ans;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        cfg_wr_en;
    logic [9:0]  cfg_wr_data;

    tree_lowest_common_ancestor dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    // shadow of the block: bit 10 of a jump entry marks "no ancestor"
    logic [10:0] jump_shadow [NODES][LEVELS];
    logic [9:0]  depth_shadow [NODES];
    int          tree_size;

    word_t   send_q[$];
    answer_t answer_q[$];
    int      errors;
    int      words_issued;
    int      words_taken;
    bit      hold_request;
    int      parent_of [NODES];
    int      depth_of [NODES];

    // copy of what was queued, so fixed expectations travel with their word
    word_t send_log[$];

    function automatic int level_cap(int x);
        int lg;
        lg = 0;
        while (lg < LEVELS - 1 && (1 << (lg + 1)) <= x)
            lg++;
        return lg;
    endfunction

    function automatic void rebuild_jumps();
        int lg;
        logic [10:0] a;
        lg = level_cap(tree_size);
        for (int j = 0; j <= lg; j++)
            jump_shadow[0][j] = 11'h400;
        for (int i = 1; i <= tree_size && i < NODES; i++)
            for (int j = 1; j <= lg; j++)
                jump_shadow[i][j] = 11'h400;
        for (int j = 1; j <= lg; j++)
            for (int i = 1; i <= tree_size && i < NODES; i++) begin
                a = jump_shadow[i][j-1];
                if (!a[10])
                    jump_shadow[i][j] = jump_shadow[a[9:0]][j-1];
            end
    endfunction

    function automatic logic [9:0] common_ancestor(logic [9:0] u, logic [9:0] v);
        logic [9:0] t;
        logic [10:0] a;
        logic [10:0] b;
        int lg;
        if (depth_shadow[u] < depth_shadow[v]) begin
            t = u;
            u = v;
            v = t;
        end
        lg = level_cap(depth_shadow[u]);
        for (int i = lg; i >= 0; i--) begin
            a = jump_shadow[u][i];
            if (!a[10] && depth_shadow[a[9:0]] >= depth_shadow[v])
                u = a[9:0];
        end
        if (u == v)
            return u;
        for (int i = lg; i >= 0; i--) begin
            a = jump_shadow[u][i];
            b = jump_shadow[v][i];
            if (!a[10] && b != a) begin
                u = a[9:0];
                if (b[10])
                    return 0;
                v = b[9:0];
            end
        end
        a = jump_shadow[u][0];
        if (a[10])
            return 0;
        return a[9:0];
    endfunction

    function automatic answer_t predict_answer(word_t w);
        answer_t r;
        r.anc = 0;
        r.ans = 0;
        case (w.op)
            OP_LOAD:
                if (w.node != 0) begin
                    jump_shadow[w.node][0] = {1'b0, w.parent};
                    depth_shadow[w.node] = w.depth;
                end
            OP_BUILD: rebuild_jumps();
            OP_QUERY: begin
                r.anc = common_ancestor(w.node, w.other);
                r.ans = 1;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic word_t make_word(logic [1:0] op, int n, int p, int d, int o);
        word_t w;
        w.op = op;
        w.node = 10'(n);
        w.parent = 10'(p);
        w.depth = 10'(d);
        w.other = 10'(o);
        w.fixed = 0;
        w.fixed_anc = 0;
        w.fixed_ans = 0;
        return w;
    endfunction

    function automatic word_t fixed_word(logic [1:0] op, int n, int p, int d, int o,
                                         int anc, int ans);
        word_t w;
        w = make_word(op, n, p, d, o);
        w.fixed = 1;
        w.fixed_anc = 10'(anc);
        w.fixed_ans = 1'(ans);
        return w;
    endfunction

    task automatic queue_word(word_t w);
        send_q.insert(send_q.size(), w);
        send_log.insert(send_log.size(), w);
        words_issued++;
    endtask

    task automatic wait_idle();
        wait (words_taken == words_issued && answer_q.size() == 0);
        repeat (30) @(negedge clk);
    endtask

    task automatic set_tree_size(int n);
        wait_idle();
        cfg_wr_en <= 1;
        cfg_wr_data <= 10'(n);
        @(negedge clk);
        cfg_wr_en <= 0;
        tree_size = n;
    endtask

    // shape: 0 chain, 1 bushy, 2 nearly a chain
    task automatic load_tree(int n, int shape);
        parent_of[1] = 1;
        depth_of[1] = 0;
        queue_word(make_word(OP_LOAD, 1, 1, 0, $urandom));
        for (int i = 2; i <= n; i++) begin
            case (shape)
                0: parent_of[i] = i - 1;
                1: parent_of[i] = $urandom_range(1, i - 1);
                default: parent_of[i] = (i > 4) ? i - 1 - $urandom_range(0, 3) : i - 1;
            endcase
            depth_of[i] = depth_of[parent_of[i]] + 1;
            queue_word(make_word(OP_LOAD, i, parent_of[i], depth_of[i], $urandom));
        end
        queue_word(make_word(OP_BUILD, $urandom, $urandom, $urandom, $urandom));
    endtask

    task automatic ask_queries(int n, int count);
        int u;
        int r;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 19);
            u = $urandom_range(1, n);
            if (r == 0)
                queue_word(make_word(OP_UNUSED, $urandom, $urandom, $urandom, $urandom));
            else if (r == 1)
                queue_word(make_word(OP_LOAD, 0, $urandom, $urandom, $urandom));
            else if (r == 2)
                queue_word(make_word(OP_QUERY, u, $urandom, $urandom, u));
            else if (r == 3)
                queue_word(make_word(OP_QUERY, u, $urandom, $urandom, parent_of[u]));
            else
                queue_word(make_word(OP_QUERY, u, $urandom, $urandom, $urandom_range(1, n)));
        end
    endtask

    initial begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial begin
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tuser = 0;
        m_tready = 0;
        cfg_wr_en = 0;
        cfg_wr_data = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
    end

    initial begin
        #50ms;
        $display("** tree_lowest_common_ancestor: FAILED **");
        $finish;
    end

    // sender: bursts with random gaps between them
    initial begin
        word_t w;
        int burst;
        int gap;
        burst = 0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (send_q.size() == 0) begin
                s_tvalid <= 0;
                continue;
            end
            if (burst == 0) begin
                burst = $urandom_range(1, 40);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                if (gap > 0) begin
                    s_tvalid <= 0;
                    repeat (gap) @(negedge clk);
                end
            end
            burst--;
            w = send_q.pop_front();
            s_tvalid <= 1;
            s_tuser <= w.op;
            s_tdata <= {w.other, w.depth, w.parent, w.node};
            do @(posedge clk); while (!s_tready);
        end
    end

    // receiver: own stall pattern, plus one long hold on request
    initial begin
        int mode;
        int stretch;
        @(posedge rst_n);
        forever begin
            mode = $urandom_range(0, 2);
            stretch = $urandom_range(10, 80);
            for (int k = 0; k < stretch; k++) begin
                @(negedge clk);
                if (hold_request) begin
                    m_tready <= 0;
                    repeat (400) @(negedge clk);
                    hold_request = 0;
                end
                if (mode == 0)
                    m_tready <= 1;
                else if (mode == 1)
                    m_tready <= $urandom_range(0, 1);
                else
                    m_tready <= ($urandom_range(0, 4) != 0);
            end
        end
    end

    // accepted words feed the shadow model, results are checked in order
    always @(posedge clk) begin
        word_t w;
        answer_t r;
        answer_t got;
        if (rst_n && s_tvalid && s_tready) begin
            w = send_log.pop_front();
            r = predict_answer(w);
            if (w.fixed) begin
                r.anc = w.fixed_anc;
                r.ans = w.fixed_ans;
            end
            answer_q.insert(answer_q.size(), r);
            words_taken++;
        end
        if (rst_n && m_tvalid && m_tready) begin
            if (answer_q.size() == 0) begin
                $error("result word with nothing expected: tdata %h", m_tdata);
                errors++;
            end else begin
                got = answer_q.pop_front();
                if (m_tdata !== {6'd0, got.anc}) begin
                    $error("ancestor: expected %0d, actual %0d", got.anc, m_tdata);
                    errors++;
                end
                if (m_tuser !== got.ans) begin
                    $error("answer_valid: expected %0d, actual %0d", got.ans, m_tuser);
                    errors++;
                end
            end
        end
    end

    word_t directed [$];

    initial begin
        int n;
        errors = 0;
        words_issued = 0;
        words_taken = 0;
        hold_request = 0;
        tree_size = 1;
        @(posedge rst_n);

        // node_count is 1 after reset: a lone root
        directed.insert(directed.size(), fixed_word(OP_LOAD, 1, 1, 0, 0, 0, 0));
        directed.insert(directed.size(), fixed_word(OP_LOAD, 0, 1023, 1023, 1023, 0, 0));
        directed.insert(directed.size(), fixed_word(OP_BUILD, 1023, 1023, 1023, 1023, 0, 0));
        directed.insert(directed.size(), fixed_word(OP_QUERY, 1, 0, 0, 1, 1, 1));
        directed.insert(directed.size(), fixed_word(OP_QUERY, 1, 1023, 1023, 1, 1, 1));
        directed.insert(directed.size(), fixed_word(OP_UNUSED, 0, 0, 0, 0, 0, 0));
        directed.insert(directed.size(), fixed_word(OP_UNUSED, 1023, 1023, 1023, 1023, 0, 0));
        directed.insert(directed.size(), fixed_word(OP_LOAD, 0, 0, 0, 0, 0, 0));
        directed.insert(directed.size(), make_word(OP_QUERY, 1, 512, 512, 1));
        foreach (directed[k])
            queue_word(directed[k]);

        // random parts
        for (int phase = 0; words_issued < 1900 || phase < 3; phase++) begin
            if (phase == 0)
                n = 2;
            else if (phase == 1)
                n = 1023;
            else if (phase % 7 == 6)
                n = 1;
            else
                n = $urandom_range(3, 60);
            set_tree_size(n);
            load_tree(n, (phase == 1) ? 2 : $urandom_range(0, 2));
            ask_queries(n, (phase == 1) ? 150 : 30);
            if (phase == 1) begin
                wait (words_taken > words_issued - 100);
                hold_request = 1;
            end
        end

        wait (words_taken == words_issued && answer_q.size() == 0);
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("** tree_lowest_common_ancestor: PASSED **");
        else
            $display("** tree_lowest_common_ancestor: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
src/tlca_pkg.sv
src/tree_lowest_common_ancestor.sv
dv/testbench.sv
